@@ hdl/dwc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared constants, codes and word types of the 3x3 depthwise convolution.
// ----------------------------------------------------------------------------
package dwc_pkg;

    // default sizes handed to the top level
    localparam int DEF_MAX_WIDTH = 64;
    localparam int DEF_CHANNELS  = 8;

    // kernel geometry
    localparam int KSIZE = 3;
    localparam int TAPS  = KSIZE * KSIZE;

    // field widths of the ports
    localparam int SMP_W      = 16;
    localparam int TAP_IDX_W  = 4;
    localparam int WCH_W      = 3;
    localparam int ROW_W      = 10;
    localparam int OCOL_W     = 6;
    localparam int OCH_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register widths and reset values
    localparam int CW_WIDTH    = 7;
    localparam int CW_HEIGHT   = 10;
    localparam int CW_CHANNELS = 4;
    localparam int RST_WIDTH    = 64;
    localparam int RST_HEIGHT   = 64;
    localparam int RST_CHANNELS = 8;

    // arithmetic: Q7.8 by Q1.14, rounded half up back to Q7.8
    localparam int PROD_W     = 2 * SMP_W;
    localparam int ROWSUM_W   = PROD_W + 2;
    localparam int ACC_W      = PROD_W + 4;
    localparam int ROUND_BIAS = 8192;
    localparam int FRAC_SHIFT = 14;

    // result buffer depth
    localparam int FIFO_DEPTH = 8;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CHANNELS = 2'd2
    } cfg_idx_t;

    // position and framing of one result
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic [OCH_W-1:0]  chan;
        logic              last;
    } out_meta_t;

    // operands of one result handed to the multiply-accumulate pipeline
    typedef struct packed {
        logic [TAPS-1:0][SMP_W-1:0] smp;
        logic [TAPS-1:0][SMP_W-1:0] wgt;
        out_meta_t                  meta;
    } mac_op_t;

    // finished result
    typedef struct packed {
        logic [SMP_W-1:0] value;
        logic             sat;
        out_meta_t        meta;
    } mac_res_t;

endpackage

@@ hdl/dwc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/dwc_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc_mac
// Nine-tap multiply-accumulate pipeline with rounding and saturation.
// ----------------------------------------------------------------------------
module dwc_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  dwc_pkg::mac_op_t   op,
    output logic               res_valid,
    output dwc_pkg::mac_res_t  res,
    output logic [1:0]         inflight
);

    import dwc_pkg::*;

    logic                             p0_v_reg;
    mac_op_t                          p0_reg;
    logic                             p1_v_reg;
    logic signed [PROD_W-1:0]         prod_reg [TAPS];
    logic signed [PROD_W-1:0]         prod_next [TAPS];
    out_meta_t                        p1_meta_reg;
    logic                             p2_v_reg;
    logic signed [ROWSUM_W-1:0]       rsum_reg [KSIZE];
    logic signed [ROWSUM_W-1:0]       rsum_next [KSIZE];
    out_meta_t                        p2_meta_reg;
    logic signed [ACC_W-1:0]          acc;
    logic signed [ACC_W-1:0]          shifted;
    logic [ACC_W-1:SMP_W-1]           hi_bits;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else
        begin
            p0_v_reg <= op_valid;
            p1_v_reg <= p0_v_reg;
            p2_v_reg <= p1_v_reg;
        end
    end

    // products, one multiplier per tap
    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            prod_next[t] = PROD_W'($signed(p0_reg.smp[t]) * $signed(p0_reg.wgt[t]));
        end
    end

    // row sums of three products each
    always_comb
    begin
        for (int y = 0; y < KSIZE; y++)
        begin
            rsum_next[y] = ROWSUM_W'(prod_reg[y * KSIZE])
                         + ROWSUM_W'(prod_reg[y * KSIZE + 1])
                         + ROWSUM_W'(prod_reg[y * KSIZE + 2]);
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        p0_reg <= op;
        for (int t = 0; t < TAPS; t++)
        begin
            prod_reg[t] <= prod_next[t];
        end
        p1_meta_reg <= p0_reg.meta;
        for (int y = 0; y < KSIZE; y++)
        begin
            rsum_reg[y] <= rsum_next[y];
        end
        p2_meta_reg <= p1_meta_reg;
    end

    // final sum, round half up and clip to 16 bits
    always_comb
    begin
        acc = ACC_W'(rsum_reg[0]) + ACC_W'(rsum_reg[1]) + ACC_W'(rsum_reg[2])
            + ACC_W'(ROUND_BIAS);
        shifted = acc >>> FRAC_SHIFT;
        hi_bits = shifted[ACC_W-1:SMP_W-1];
        res.meta = p2_meta_reg;
        if ((&hi_bits) || !(|hi_bits))
        begin
            res.sat   = 1'b0;
            res.value = shifted[SMP_W-1:0];
        end
        else
        begin
            res.sat   = 1'b1;
            res.value = shifted[ACC_W-1] ? {1'b1, {(SMP_W-1){1'b0}}}
                                         : {1'b0, {(SMP_W-1){1'b1}}};
        end
    end

    assign res_valid = p2_v_reg;
    assign inflight  = {1'b0, p0_v_reg} + {1'b0, p1_v_reg} + {1'b0, p2_v_reg};

endmodule

@@ hdl/depthwise_conv_3x3_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depthwise_conv_3x3_top
// Per-channel 3x3 depthwise convolution over a raster stream, zero padded.
// ----------------------------------------------------------------------------
// Takes one word per clock, samples and weight writes alike, as long as each
// sample causes at most one result and the result buffer has room; a sample
// on the last row or last column that causes several results holds the input
// while they issue, as the single multiply-accumulate issue slot produces at
// most one result per clock. The line store (two rows per column and
// channel) and the per-channel column history are read when a sample is
// taken and written back as the read-return stage advances, with the last
// write forwarded, so even a one-pixel, one-channel image runs at full rate.
// A result waits in an eight-word buffer while the output is stalled.
// Stale store contents from an earlier frame are masked by position, so no
// clearing pass is needed after reset. Weights must be written for every
// channel in use before samples arrive.
module depthwise_conv_3x3_top #(
    parameter int MAX_WIDTH = dwc_pkg::DEF_MAX_WIDTH,
    parameter int CHANNELS  = dwc_pkg::DEF_CHANNELS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic signed [dwc_pkg::SMP_W-1:0]    sample,
    input  logic signed [dwc_pkg::SMP_W-1:0]    weight,
    input  logic [dwc_pkg::TAP_IDX_W-1:0]       tap_index,
    input  logic [dwc_pkg::WCH_W-1:0]           weight_channel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dwc_pkg::SMP_W-1:0]    out_value,
    output logic [dwc_pkg::ROW_W-1:0]           out_row,
    output logic [dwc_pkg::OCOL_W-1:0]          out_col,
    output logic [dwc_pkg::OCH_W-1:0]           out_channel,
    output logic                                saturated,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dwc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dwc_pkg::*;

    localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int EC_W       = $clog2(CHANNELS + 1);
    localparam int LINE_DEPTH = MAX_WIDTH * CHANNELS;
    localparam int LA_W       = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LINE_W     = 2 * SMP_W;
    localparam int COLV_W     = KSIZE * SMP_W;
    localparam int HIST_W     = 2 * COLV_W;
    localparam int FP_W       = $clog2(FIFO_DEPTH);
    localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

    // configuration and position
    logic [CW_WIDTH-1:0]    width_reg;
    logic [CW_HEIGHT-1:0]   height_reg;
    logic [CW_CHANNELS-1:0] chans_reg;
    logic [EW_W-1:0]        eff_w;
    logic [ROW_W-1:0]       eff_h;
    logic [EC_W-1:0]        eff_c;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [CH_W-1:0]        chan_reg;
    logic                   chan_wrap;
    logic                   col_wrap;
    logic                   row_wrap;

    // input handshake
    logic                   accept;
    logic                   smp_acc;
    logic                   wgt_acc;
    logic [LA_W-1:0]        line_addr;
    logic [3:0]             s0_mask;

    // read-return stage
    logic                   s1_v_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [CH_W-1:0]        s1_chan_reg;
    logic [SMP_W-1:0]       s1_smp_reg;
    logic [3:0]             s1_mask_reg;
    logic [LA_W-1:0]        s1_laddr_reg;
    logic                   s1_adv;
    logic                   s1_wr;

    // memories and forwarding
    logic [LINE_W-1:0]             line_rdata;
    logic [HIST_W-1:0]             hist_rdata;
    logic [TAPS-1:0][SMP_W-1:0]    wgt_rdata;
    logic                          lfwd_v_reg;
    logic [LA_W-1:0]               lfwd_addr_reg;
    logic [LINE_W-1:0]             lfwd_data_reg;
    logic                          hfwd_v_reg;
    logic [CH_W-1:0]               hfwd_addr_reg;
    logic [HIST_W-1:0]             hfwd_data_reg;
    logic [LINE_W-1:0]             line_rd;
    logic [HIST_W-1:0]             hist_rd;
    logic [LINE_W-1:0]             line_wdata;
    logic [HIST_W-1:0]             hist_wdata;
    logic [COLV_W-1:0]             cur_col;
    logic [TAPS-1:0][SMP_W-1:0]    win;

    // window stage and sequencer
    logic                          w2_v_reg;
    logic [TAPS-1:0][SMP_W-1:0]    w2_win_reg;
    logic [TAPS-1:0][SMP_W-1:0]    w2_wgt_reg;
    logic [ROW_W-1:0]              w2_row_reg;
    logic [COL_W-1:0]              w2_col_reg;
    logic [CH_W-1:0]               w2_chan_reg;
    logic [3:0]                    rem_reg;
    logic [3:0]                    rem_next;
    logic [3:0]                    rem_after;
    logic [1:0]                    sel_k;
    logic                          issue_ok;
    logic                          issue;
    logic                          w2_pop;
    logic [3:0][3:0][SMP_W-1:0]    pad;
    mac_op_t                       op;

    // pipeline and result buffer
    logic                          res_valid;
    mac_res_t                      res;
    logic [1:0]                    inflight;
    mac_res_t                      fifo_mem [FIFO_DEPTH];
    logic [FP_W-1:0]               wr_ptr_reg;
    logic [FP_W-1:0]               rd_ptr_reg;
    logic [FC_W-1:0]               count_reg;
    logic                          fifo_pop;
    mac_res_t                      head;

    assign cfg_ready = 1'b1;

    // effective sizes, clamped
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = EW_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(width_reg);
        end
        eff_h = (height_reg == '0) ? ROW_W'(1) : height_reg;
        if (chans_reg == '0)
        begin
            eff_c = EC_W'(1);
        end
        else if (32'(chans_reg) > CHANNELS)
        begin
            eff_c = EC_W'(CHANNELS);
        end
        else
        begin
            eff_c = EC_W'(chans_reg);
        end
    end

    // input acceptance
    assign in_stall = s1_v_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;
    assign smp_acc  = accept && (command == CMD_SAMPLE);
    assign wgt_acc  = accept && (command == CMD_WEIGHT) && (32'(tap_index) < TAPS)
                      && (32'(weight_channel) < CHANNELS);

    // position wrap and output mask of the sample being taken
    assign chan_wrap = (32'(chan_reg) + 32'd1) >= 32'(eff_c);
    assign col_wrap  = (32'(col_reg) + 32'd1) >= 32'(eff_w);
    assign row_wrap  = (32'(row_reg) + 32'd1) >= 32'(eff_h);
    assign line_addr = LA_W'(32'(col_reg) * CHANNELS + 32'(chan_reg));
    assign s0_mask[0] = (row_reg != '0) && (col_reg != '0);
    assign s0_mask[1] = (row_reg != '0) && col_wrap;
    assign s0_mask[2] = (row_reg == eff_h - ROW_W'(1)) && (col_reg != '0);
    assign s0_mask[3] = (row_reg == eff_h - ROW_W'(1)) && col_wrap;

    // configuration registers and raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW_WIDTH'(RST_WIDTH);
            height_reg <= CW_HEIGHT'(RST_HEIGHT);
            chans_reg  <= CW_CHANNELS'(RST_CHANNELS);
            row_reg    <= '0;
            col_reg    <= '0;
            chan_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:
                begin
                    width_reg <= cfg_data[CW_WIDTH-1:0];
                    row_reg   <= '0;
                    col_reg   <= '0;
                    chan_reg  <= '0;
                end
                CFG_HEIGHT:
                begin
                    height_reg <= cfg_data[CW_HEIGHT-1:0];
                    row_reg    <= '0;
                    col_reg    <= '0;
                    chan_reg   <= '0;
                end
                CFG_CHANNELS:
                begin
                    chans_reg <= cfg_data[CW_CHANNELS-1:0];
                    row_reg   <= '0;
                    col_reg   <= '0;
                    chan_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (smp_acc)
        begin
            if (!chan_wrap)
            begin
                chan_reg <= chan_reg + CH_W'(1);
            end
            else
            begin
                chan_reg <= '0;
                if (!col_wrap)
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
                else
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : row_reg + ROW_W'(1);
                end
            end
        end
    end

    // weight store, one RAM per tap
    for (genvar t = 0; t < TAPS; t++)
    begin : g_wgt
        dwc_ram #(
            .WIDTH (SMP_W),
            .DEPTH (CHANNELS)
        ) u_wgt_ram (
            .clk   (clk),
            .we    (wgt_acc && (32'(tap_index) == t)),
            .waddr (CH_W'(weight_channel)),
            .wdata (weight),
            .re    (smp_acc),
            .raddr (chan_reg),
            .rdata (wgt_rdata[t])
        );
    end

    // line store: rows r-1 and r-2 for each column and channel
    dwc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_laddr_reg),
        .wdata (line_wdata),
        .re    (smp_acc),
        .raddr (line_addr),
        .rdata (line_rdata)
    );

    // column history: the two previous columns of each channel
    dwc_ram #(
        .WIDTH (HIST_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_chan_reg),
        .wdata (hist_wdata),
        .re    (smp_acc),
        .raddr (chan_reg),
        .rdata (hist_rdata)
    );

    // read-return stage control
    assign s1_adv = !w2_v_reg || w2_pop;
    assign s1_wr  = s1_v_reg && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            lfwd_v_reg <= 1'b0;
            hfwd_v_reg <= 1'b0;
        end
        else
        begin
            if (smp_acc)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_v_reg <= 1'b0;
            end
            if (s1_wr)
            begin
                lfwd_v_reg <= 1'b1;
                hfwd_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_chan_reg  <= chan_reg;
            s1_smp_reg   <= sample;
            s1_mask_reg  <= s0_mask;
            s1_laddr_reg <= line_addr;
        end
        if (s1_wr)
        begin
            lfwd_addr_reg <= s1_laddr_reg;
            lfwd_data_reg <= line_wdata;
            hfwd_addr_reg <= s1_chan_reg;
            hfwd_data_reg <= hist_wdata;
        end
    end

    // forwarded reads, new column and 3x3 window
    always_comb
    begin
        line_rd = (lfwd_v_reg && (lfwd_addr_reg == s1_laddr_reg)) ? lfwd_data_reg
                                                                  : line_rdata;
        hist_rd = (hfwd_v_reg && (hfwd_addr_reg == s1_chan_reg)) ? hfwd_data_reg
                                                                 : hist_rdata;
        cur_col[SMP_W-1:0]         = s1_smp_reg;
        cur_col[2*SMP_W-1:SMP_W]   = (s1_row_reg != '0) ? line_rd[SMP_W-1:0] : '0;
        cur_col[3*SMP_W-1:2*SMP_W] = (32'(s1_row_reg) >= 32'd2)
                                     ? line_rd[2*SMP_W-1:SMP_W] : '0;
        line_wdata = {line_rd[SMP_W-1:0], s1_smp_reg};
        hist_wdata = {hist_rd[COLV_W-1:0], cur_col};
        for (int y = 0; y < KSIZE; y++)
        begin
            win[y*KSIZE+2] = cur_col[(KSIZE-1-y)*SMP_W +: SMP_W];
            win[y*KSIZE+1] = (s1_col_reg != '0)
                             ? hist_rd[(KSIZE-1-y)*SMP_W +: SMP_W] : '0;
            win[y*KSIZE]   = (32'(s1_col_reg) >= 32'd2)
                             ? hist_rd[COLV_W + (KSIZE-1-y)*SMP_W +: SMP_W] : '0;
        end
    end

    // result sequencer over the up to four centres of a window
    assign issue_ok = (32'(count_reg) + 32'(inflight)) < FIFO_DEPTH;

    always_comb
    begin
        if (rem_reg[0])
        begin
            sel_k = 2'd0;
        end
        else if (rem_reg[1])
        begin
            sel_k = 2'd1;
        end
        else if (rem_reg[2])
        begin
            sel_k = 2'd2;
        end
        else
        begin
            sel_k = 2'd3;
        end
        rem_after = rem_reg & ~(4'b0001 << sel_k);
        issue     = w2_v_reg && (rem_reg != '0) && issue_ok;
        w2_pop    = w2_v_reg && ((rem_reg == '0) || (issue && (rem_after == '0)));
        if (s1_wr)
        begin
            rem_next = s1_mask_reg;
        end
        else if (issue)
        begin
            rem_next = rem_after;
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w2_v_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (s1_wr)
            begin
                w2_v_reg <= 1'b1;
            end
            else if (w2_pop)
            begin
                w2_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_wr)
        begin
            w2_win_reg  <= win;
            w2_wgt_reg  <= wgt_rdata;
            w2_row_reg  <= s1_row_reg;
            w2_col_reg  <= s1_col_reg;
            w2_chan_reg <= s1_chan_reg;
        end
    end

    // operands for the chosen centre, bottom and right padding as zeros
    always_comb
    begin
        pad = '0;
        for (int y = 0; y < KSIZE; y++)
        begin
            for (int x = 0; x < KSIZE; x++)
            begin
                pad[y][x] = w2_win_reg[y*KSIZE+x];
            end
        end
        for (int ty = 0; ty < KSIZE; ty++)
        begin
            for (int tx = 0; tx < KSIZE; tx++)
            begin
                op.smp[ty*KSIZE+tx] = pad[2'(ty) + {1'b0, sel_k[1]}]
                                         [2'(tx) + {1'b0, sel_k[0]}];
            end
        end
        op.wgt       = w2_wgt_reg;
        op.meta.row  = sel_k[1] ? w2_row_reg : w2_row_reg - ROW_W'(1);
        op.meta.col  = OCOL_W'(sel_k[0] ? w2_col_reg : w2_col_reg - COL_W'(1));
        op.meta.chan = OCH_W'(w2_chan_reg);
        op.meta.last = (rem_after == '0);
    end

    dwc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (issue),
        .op        (op),
        .res_valid (res_valid),
        .res       (res),
        .inflight  (inflight)
    );

    // result buffer
    assign fifo_pop = (count_reg != '0) && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (res_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FP_W'(1);
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FP_W'(1);
            end
            count_reg <= count_reg + FC_W'(res_valid) - FC_W'(fifo_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    // output word from the buffer head
    assign head        = fifo_mem[rd_ptr_reg];
    assign out_valid   = (count_reg != '0);
    assign out_value   = head.value;
    assign out_row     = head.meta.row;
    assign out_col     = head.meta.col;
    assign out_channel = head.meta.chan;
    assign saturated   = head.sat;
    assign last        = head.meta.last;

endmodule
